// File: hdl/backing_store_region_map_defines.svh
// Assertion macros used by the backing store region map top level.
`ifndef BACKING_STORE_REGION_MAP_DEFINES_SVH
`define BACKING_STORE_REGION_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define BSRM_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BSRM_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BSRM_ASSERT_IMP(label, clk, rstn, ante, cons)
`define BSRM_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/bsrm_pkg.sv
// Types, opcodes and constants of the backing store region map.
package bsrm_pkg;
    localparam int DEF_STORES    = 16;
    localparam int DEF_PROCESSES = 64;
    localparam int DEF_MAX_PAGES = 256;

    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_GETFREE = 3'd1;
    localparam logic [2:0] OP_FREE    = 3'd2;
    localparam logic [2:0] OP_LOOKUP  = 3'd3;
    localparam logic [2:0] OP_MAP     = 3'd4;
    localparam logic [2:0] OP_UNMAP   = 3'd5;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam logic [19:0] BASE_NONE     = 20'hFFFFF;
    localparam logic [19:0] BASE_UNMAPPED = 20'd4096;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  pid;
        logic [31:0] vaddr;
        logic [19:0] vpno;
        logic [4:0]  store_id;
        logic [8:0]  npages;
    } req_t;

    typedef struct packed {
        logic       status;
        logic [3:0] store_index;
        logic [7:0] page_index;
    } rsp_t;

    typedef struct packed {
        logic        owner;
        logic [19:0] base;
        logic [8:0]  pages;
    } region_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] offset;
    } match_t;

    localparam region_t REGION_CLEAR = '{owner: 1'b0, base: BASE_NONE, pages: 9'd0};
    localparam region_t REGION_UNMAP = '{owner: 1'b0, base: BASE_UNMAPPED, pages: 9'd0};
endpackage

// File: hdl/bsrm_ram.sv
// Generic single write port RAM with a registered read port.
module bsrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hdl/bsrm_match.sv
// Shared range compare unit: tests one region entry against a page.
module bsrm_match (
    input  bsrm_pkg::region_t entry,
    input  logic [19:0]       page,
    output bsrm_pkg::match_t  result
);
    import bsrm_pkg::*;

    logic [20:0] limit;
    logic [19:0] diff;

    always_comb begin
        limit = {1'b0, entry.base} + {12'd0, entry.pages};
        diff  = page - entry.base;
        result.hit    = entry.owner && (page >= entry.base) && ({1'b0, page} < limit);
        result.offset = diff[7:0];
    end
endmodule

// File: hdl/backing_store_region_map.sv
// Top level of the backing store region map: sequencer, tables and result register.
//
// One request enters on s_valid/s_ready with an s_data struct; one response
// leaves on m_valid/m_ready with an m_data struct. One request is worked at a
// time and s_ready stays low until its response is loaded into the output
// register. Lookup and unmap walk the region RAM one store entry per step
// and get-free scans the mapped flags one store per step; init sweeps the
// whole region RAM, free sweeps the entries of one store, and an unmap that
// releases its store adds a sweep over the entries of that store.
// After reset the block sweeps the whole region RAM and the holds RAM, one
// entry a cycle (2**(clog2(STORES)+clog2(PROCESSES)) entries, 1024 by default),
// with s_ready low. A stalled receiver keeps the response in the output
// register; a new request is still taken and its response waits until the
// register frees.
module backing_store_region_map #(
    parameter int STORES    = bsrm_pkg::DEF_STORES,
    parameter int PROCESSES = bsrm_pkg::DEF_PROCESSES,
    parameter int MAX_PAGES = bsrm_pkg::DEF_MAX_PAGES
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bsrm_pkg::req_t s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output bsrm_pkg::rsp_t m_data
);
    import bsrm_pkg::*;
    `include "backing_store_region_map_defines.svh"

    localparam int SW = (STORES > 1) ? $clog2(STORES) : 1;
    localparam int PW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int AW = SW + PW;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_GF    = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_UPD   = 4'd5;
    localparam logic [3:0] S_SWEEP = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0]        state_reg, state_next;
    req_t              req_reg, req_next;
    rsp_t              res_reg, res_next;
    rsp_t              m_data_reg, m_data_next;
    logic              m_valid_reg, m_valid_next;
    logic [SW-1:0]     k_reg, k_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [SW-1:0]     sw_s_reg, sw_s_next;
    logic              sw_all_reg, sw_all_next;
    logic              sw_rst_reg, sw_rst_next;
    logic [STORES-1:0] mapped_reg, mapped_next;
    logic [STORES-1:0] refs_reg, refs_next;

    logic              rg_we;
    logic [AW-1:0]     rg_waddr, rg_raddr;
    region_t           rg_wdata, rg_rdata;
    logic              hd_we;
    logic [PW-1:0]     hd_waddr;
    logic [STORES-1:0] hd_wdata, hd_rdata;
    logic [SW-1:0]     sid;
    logic [PW-1:0]     pid;
    logic              sid_ok, pid_ok, np_ok, k_last, sw_done, refs_after;
    logic [19:0]       page;
    match_t            mres;

    assign sid    = SW'(req_reg.store_id);
    assign pid    = PW'(req_reg.pid);
    assign sid_ok = 32'(req_reg.store_id) < 32'(STORES);
    assign pid_ok = 32'(req_reg.pid) < 32'(PROCESSES);
    assign np_ok  = (req_reg.npages != 9'd0) && (32'(req_reg.npages) <= 32'(MAX_PAGES));
    assign k_last = 32'(k_reg) == 32'(STORES - 1);
    assign page   = (req_reg.op == OP_LOOKUP) ? req_reg.vaddr[31:12] : req_reg.vpno;
    assign sw_done = sw_all_reg ? (cnt_reg == {AW{1'b1}})
                                : (32'(cnt_reg[PW-1:0]) == 32'(PROCESSES - 1));
    assign rg_raddr = {k_reg, pid};
    assign refs_after = hd_rdata[k_reg] ? 1'b0 : refs_reg[k_reg];

    bsrm_ram #(.WIDTH($bits(region_t)), .DEPTH(2 ** AW)) u_region_ram (
        .aclk  (aclk),
        .we    (rg_we),
        .waddr (rg_waddr),
        .wdata (rg_wdata),
        .raddr (rg_raddr),
        .rdata (rg_rdata)
    );

    bsrm_ram #(.WIDTH(STORES), .DEPTH(2 ** PW)) u_holds_ram (
        .aclk  (aclk),
        .we    (hd_we),
        .waddr (hd_waddr),
        .wdata (hd_wdata),
        .raddr (pid),
        .rdata (hd_rdata)
    );

    bsrm_match u_match (
        .entry  (rg_rdata),
        .page   (page),
        .result (mres)
    );

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        res_next    = res_reg;
        m_data_next = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        k_next      = k_reg;
        cnt_next    = cnt_reg;
        sw_s_next   = sw_s_reg;
        sw_all_next = sw_all_reg;
        sw_rst_next = sw_rst_reg;
        mapped_next = mapped_reg;
        refs_next   = refs_reg;
        rg_we       = 1'b0;
        rg_waddr    = {sid, pid};
        rg_wdata    = REGION_CLEAR;
        hd_we       = 1'b0;
        hd_waddr    = pid;
        hd_wdata    = hd_rdata;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_data;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                res_next = '{status: ST_ERR, store_index: 4'd0, page_index: 8'd0};
                k_next   = '0;
                cnt_next = '0;
                state_next = S_OUT;
                case (req_reg.op)
                    OP_INIT: begin
                        mapped_next = '0;
                        refs_next   = '0;
                        sw_all_next = 1'b1;
                        sw_rst_next = 1'b0;
                        res_next.status = ST_OK;
                        state_next  = S_SWEEP;
                    end
                    OP_GETFREE: state_next = S_GF;
                    OP_FREE: begin
                        if (sid_ok) begin
                            mapped_next[sid] = 1'b0;
                            refs_next[sid]   = 1'b0;
                            sw_s_next   = sid;
                            sw_all_next = 1'b0;
                            sw_rst_next = 1'b0;
                            res_next.status = ST_OK;
                            state_next  = S_SWEEP;
                        end
                    end
                    OP_LOOKUP, OP_UNMAP: begin
                        if (pid_ok) begin
                            state_next = S_RD;
                        end
                    end
                    OP_MAP: begin
                        if (pid_ok && sid_ok && np_ok) begin
                            state_next = S_UPD;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_GF: begin
                if (!mapped_reg[k_reg]) begin
                    res_next.status      = ST_OK;
                    res_next.store_index = 4'(k_reg);
                    state_next = S_OUT;
                end else if (k_last) begin
                    state_next = S_OUT;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_RD: state_next = S_CHK;
            S_CHK: begin
                if (mres.hit) begin
                    if (req_reg.op == OP_LOOKUP) begin
                        res_next.status      = ST_OK;
                        res_next.store_index = 4'(k_reg);
                        res_next.page_index  = mres.offset;
                        state_next = S_OUT;
                    end else if (mapped_reg[k_reg]) begin
                        state_next = S_UPD;
                    end else begin
                        state_next = S_OUT;
                    end
                end else if (k_last) begin
                    state_next = S_OUT;
                end else begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_UPD: begin
                res_next.status = ST_OK;
                rg_we = 1'b1;
                hd_we = 1'b1;
                state_next = S_OUT;
                if (req_reg.op == OP_MAP) begin
                    rg_wdata = '{owner: 1'b1, base: req_reg.vpno, pages: req_reg.npages};
                    hd_wdata[sid]    = 1'b1;
                    mapped_next[sid] = 1'b1;
                    refs_next[sid]   = 1'b1;
                end else begin
                    rg_waddr = {k_reg, pid};
                    rg_wdata = REGION_UNMAP;
                    hd_wdata[k_reg]  = 1'b0;
                    refs_next[k_reg] = refs_after;
                    if (!refs_after) begin
                        // Last reference gone: release the whole store.
                        mapped_next[k_reg] = 1'b0;
                        sw_s_next   = k_reg;
                        sw_all_next = 1'b0;
                        sw_rst_next = 1'b0;
                        state_next  = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                rg_we    = 1'b1;
                rg_waddr = sw_all_reg ? cnt_reg : {sw_s_reg, cnt_reg[PW-1:0]};
                hd_we    = sw_rst_reg;
                hd_waddr = cnt_reg[PW-1:0];
                hd_wdata = '0;
                cnt_next = cnt_reg + 1'b1;
                if (sw_done) begin
                    state_next = sw_rst_reg ? S_IDLE : S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            m_valid_reg <= 1'b0;
            mapped_reg  <= '0;
            refs_reg    <= '0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            sw_all_reg  <= 1'b1;
            sw_rst_reg  <= 1'b1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            mapped_reg  <= mapped_next;
            refs_reg    <= refs_next;
            cnt_reg     <= cnt_next;
            k_reg       <= k_next;
            sw_all_reg  <= sw_all_next;
            sw_rst_reg  <= sw_rst_next;
        end
        req_reg    <= req_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
        sw_s_reg   <= sw_s_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `BSRM_ASSERT_NXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready)
    `BSRM_ASSERT_IMP(a_rsp_from_out, aclk, aresetn, $rose(m_valid_reg),
        $past(state_reg) == S_OUT)
    `BSRM_ASSERT_IMP(a_scan_in_range, aclk, aresetn,
        state_reg == S_CHK || state_reg == S_GF, 32'(k_reg) < 32'(STORES))
    `BSRM_ASSERT_NXT(a_map_sets_refs, aclk, aresetn,
        state_reg == S_UPD && req_reg.op == OP_MAP, mapped_reg[sid] && refs_reg[sid])
endmodule

// File: test/tb_top.sv
// Self-checking testbench for the backing store region map.
`timescale 1ns / 100ps

module tb_top;
    import bsrm_pkg::*;

    localparam int NSTORE = 16;
    localparam int NPROC  = 64;
    localparam int LIMIT  = 20000;

    logic   aclk = 1'b0;
    logic   aresetn = 1'b0;
    logic   s_valid = 1'b0;
    logic   s_ready;
    req_t   s_data = '0;
    logic   m_valid;
    logic   m_ready = 1'b0;
    rsp_t   m_data;

    backing_store_region_map uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Predictor state.
    logic        mapped [NSTORE];
    logic        refs [NSTORE];
    logic        owner [NSTORE][NPROC];
    logic [19:0] base [NSTORE][NPROC];
    logic [8:0]  pages [NSTORE][NPROC];
    logic        holds [NPROC][NSTORE];

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   n_reqs = 0;
    int   n_rsps = 0;
    int   send_idle;
    int   recv_idle;
    int   hold_off = 0;
    int   quiet = 0;
    bit   stim_done = 0;

    function automatic void clear_store(int s);
        mapped[s] = 1'b0;
        refs[s] = 1'b0;
        for (int p = 0; p < NPROC; p++) begin
            owner[s][p] = 1'b0;
            base[s][p] = BASE_NONE;
            pages[s][p] = '0;
        end
    endfunction

    function automatic bit find_region(int pid, logic [19:0] page, output int s,
                                       output logic [7:0] off);
        logic [20:0] top;
        for (int k = 0; k < NSTORE; k++) begin
            top = {1'b0, base[k][pid]} + {12'd0, pages[k][pid]};
            if (owner[k][pid] && page >= base[k][pid] && {1'b0, page} < top) begin
                s = k;
                off = 8'(page - base[k][pid]);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic rsp_t predict_map(req_t r);
        rsp_t        res;
        int          s;
        logic [7:0]  off;
        logic [3:0]  sid4;
        res = '{status: ST_ERR, store_index: 4'd0, page_index: 8'd0};
        sid4 = 4'(r.store_id);
        case (r.op)
            OP_INIT: begin
                for (int k = 0; k < NSTORE; k++) clear_store(k);
                res.status = ST_OK;
            end
            OP_GETFREE: begin
                for (int k = NSTORE - 1; k >= 0; k--) begin
                    if (!mapped[k]) begin
                        res.status = ST_OK;
                        res.store_index = 4'(k);
                    end
                end
            end
            OP_FREE: begin
                if (r.store_id < NSTORE) begin
                    clear_store(int'(sid4));
                    res.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                if (find_region(r.pid, r.vaddr[31:12], s, off)) begin
                    res = '{status: ST_OK, store_index: 4'(s), page_index: off};
                end
            end
            OP_MAP: begin
                if (r.store_id < NSTORE && r.npages >= 1 && r.npages <= 256) begin
                    mapped[sid4] = 1'b1;
                    owner[sid4][r.pid] = 1'b1;
                    pages[sid4][r.pid] = r.npages;
                    base[sid4][r.pid] = r.vpno;
                    refs[sid4] = 1'b1;
                    holds[r.pid][sid4] = 1'b1;
                    res.status = ST_OK;
                end
            end
            OP_UNMAP: begin
                if (find_region(r.pid, r.vpno, s, off) && mapped[s]) begin
                    if (holds[r.pid][s]) begin
                        holds[r.pid][s] = 1'b0;
                        refs[s] = 1'b0;
                    end
                    owner[s][r.pid] = 1'b0;
                    pages[s][r.pid] = '0;
                    base[s][r.pid] = BASE_UNMAPPED;
                    if (!refs[s]) clear_store(s);
                    res.status = ST_OK;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic req_t make_req(logic [2:0] op, int pid, logic [31:0] va,
                                      int vp, int sid, int np);
        req_t r;
        r.op = op;
        r.pid = 6'(pid);
        r.vaddr = va;
        r.vpno = 20'(vp);
        r.store_id = 5'(sid);
        r.npages = 9'(np);
        return r;
    endfunction

    // Mostly well-formed traffic over a few processes and low pages so that
    // lookups and unmaps hit regions that were mapped before.
    function automatic req_t random_req();
        req_t        r;
        int          sel;
        logic [19:0] page;
        r = req_t'({$urandom, $urandom, $urandom});
        r.pid = 6'($urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) r.pid = 6'($urandom);
        page = 20'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) == 0) page = 20'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            r.op = OP_MAP;
            r.vpno = page;
            r.store_id = 5'($urandom_range(0, 15));
            r.npages = 9'($urandom_range(1, 256));
            if ($urandom_range(0, 15) == 0) r.store_id = 5'($urandom);
            if ($urandom_range(0, 15) == 0) r.npages = 9'($urandom);
        end else if (sel < 60) begin
            r.op = OP_LOOKUP;
            r.vaddr[31:12] = page;
        end else if (sel < 80) begin
            r.op = OP_UNMAP;
            r.vpno = page;
        end else if (sel < 88) begin
            r.op = OP_GETFREE;
        end else if (sel < 96) begin
            r.op = OP_FREE;
        end else if (sel < 97) begin
            r.op = OP_INIT;
        end else begin
            r.op = 3'($urandom_range(6, 7));
        end
        return r;
    endfunction

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        for (int s = 0; s < NSTORE; s++) clear_store(s);
        for (int p = 0; p < NPROC; p++)
            for (int s = 0; s < NSTORE; s++) holds[p][s] = 1'b0;

        // Directed requests: extremes, every opcode and each error case.
        pending_reqs.push_back(make_req(OP_GETFREE, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_MAP, 0, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(OP_MAP, 63, 0, 'hFFFFF, 15, 256));
        pending_reqs.push_back(make_req(OP_MAP, 1, 0, 5, 16, 10));
        pending_reqs.push_back(make_req(OP_MAP, 1, 0, 5, 31, 10));
        pending_reqs.push_back(make_req(OP_MAP, 1, 0, 5, 3, 0));
        pending_reqs.push_back(make_req(OP_MAP, 1, 0, 5, 3, 257));
        pending_reqs.push_back(make_req(OP_MAP, 1, 0, 5, 3, 511));
        pending_reqs.push_back(make_req(OP_LOOKUP, 0, 32'h0000_0FFF, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 63, 32'hFFFF_FFFF, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 0, 32'h0000_1000, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_GETFREE, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_UNMAP, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_FREE, 0, 0, 0, 15, 0));
        pending_reqs.push_back(make_req(OP_FREE, 0, 0, 0, 31, 0));
        pending_reqs.push_back(make_req(3'd6, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(3'd7, 63, '1, 'hFFFFF, 31, 511));
        for (int s = 0; s < NSTORE; s++)
            pending_reqs.push_back(make_req(OP_MAP, 2, 0, s, s, 1));
        pending_reqs.push_back(make_req(OP_GETFREE, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(OP_INIT, 0, 0, 0, 0, 0));
        for (int i = 0; i < 1600; i++) pending_reqs.push_back(random_req());
    end

    // Idling phases follow the number of requests accepted so far.
    always_comb begin
        send_idle = (n_reqs < 550) ? 26 : (n_reqs < 1100) ? 79 : 0;
        recv_idle = (n_reqs < 550) ? 79 : (n_reqs < 1100) ? 26 : 0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) n_reqs <= n_reqs + 1;
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    s_data <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // The predictor runs on acceptance, in request order.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) expected_rsps.push_back(predict_map(s_data));
    end

    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_rsps <= n_rsps + 1;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, m_data);
                    errors++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (exp_rsp.status !== m_data.status)
                        $display("%0t: status expected %0d actual %0d", $time,
                                 exp_rsp.status, m_data.status);
                    if (exp_rsp.store_index !== m_data.store_index)
                        $display("%0t: store_index expected %0d actual %0d", $time,
                                 exp_rsp.store_index, m_data.store_index);
                    if (exp_rsp.page_index !== m_data.page_index)
                        $display("%0t: page_index expected %0d actual %0d", $time,
                                 exp_rsp.page_index, m_data.page_index);
                    if (exp_rsp !== m_data) errors++;
                end
            end
            // A long receiver hold-off once the block has settled, to back up the input.
            if (n_reqs == 300 && hold_off == 0) hold_off <= 600;
            else if (hold_off > 1) hold_off <= hold_off - 1;
            if (hold_off > 1) m_ready <= 1'b0;
            else m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending_reqs.size() == 0 && !s_valid);
        wait (expected_rsps.size() == 0);
        repeat (50) @(posedge aclk);
        $display("Sent %0d requests over all six opcodes and bad codes; %0d responses checked.",
                 n_reqs, n_rsps);
        if (errors == 0 && expected_rsps.size() == 0 && !m_valid) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

// File: backing_store_region_map.f
+incdir+hdl
hdl/bsrm_pkg.sv
hdl/bsrm_ram.sv
hdl/bsrm_match.sv
hdl/backing_store_region_map.sv
test/tb_top.sv
